// ===== sv/hrbd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrbd_pkg
// shared types, codes and character helpers of the response body deframer
// ----------------------------------------------------------------------------
package hrbd_pkg;

    // result event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_BODY      = 3'd1;
    localparam logic [2:0] EV_DONE      = 3'd2;
    localparam logic [2:0] EV_NOT_200   = 3'd3;
    localparam logic [2:0] EV_BAD_STAT  = 3'd4;
    localparam logic [2:0] EV_BAD_CHUNK = 3'd5;
    localparam logic [2:0] EV_CLOSED    = 3'd6;

    // status line field stages
    localparam logic [2:0] SS_LITERAL = 3'd0;
    localparam logic [2:0] SS_SPACE1  = 3'd1;
    localparam logic [2:0] SS_TOKEN   = 3'd2;
    localparam logic [2:0] SS_SPACE2  = 3'd3;
    localparam logic [2:0] SS_SIGN    = 3'd4;
    localparam logic [2:0] SS_DIGITS  = 3'd5;
    localparam logic [2:0] SS_OK      = 3'd6;
    localparam logic [2:0] SS_BAD     = 3'd7;

    // number field stages
    localparam logic [2:0] NS_LEAD    = 3'd0;
    localparam logic [2:0] NS_SIGNED  = 3'd1;
    localparam logic [2:0] NS_DIGITS  = 3'd2;
    localparam logic [2:0] NS_STOPPED = 3'd3;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [3:0] {
        PH_STATUS      = 4'd0,
        PH_HEADERS     = 4'd1,
        PH_CSIZE       = 4'd2,
        PH_CDATA       = 4'd3,
        PH_CTAIL       = 4'd4,
        PH_CTRAILER    = 4'd5,
        PH_FIXED       = 4'd6,
        PH_FIXED_END   = 4'd7,
        PH_UNTIL_CLOSE = 4'd8,
        PH_DONE        = 4'd9
    } t_phase;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic [2:0]  event_res;
        logic [15:0] status_value;
    } t_result;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // digit valid flag and value
    function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
        logic [7:0] f;
        f = fold(b);
        if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
        if (hex && f >= "a" && f <= "f") return {1'b1, 4'(f - "a" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic [7:0] kw_http(input logic [2:0] i);
        case (i)
            3'd0: return "H";
            3'd1: return "T";
            3'd2: return "T";
            3'd3: return "P";
            default: return "/";
        endcase
    endfunction

    function automatic logic [7:0] kw_clen(input logic [4:0] i);
        case (i)
            5'd0: return "c";   5'd1: return "o";   5'd2: return "n";
            5'd3: return "t";   5'd4: return "e";   5'd5: return "n";
            5'd6: return "t";   5'd7: return "-";   5'd8: return "l";
            5'd9: return "e";   5'd10: return "n";  5'd11: return "g";
            5'd12: return "t";  5'd13: return "h";
            default: return ":";
        endcase
    endfunction

    function automatic logic [7:0] kw_tenc(input logic [4:0] i);
        case (i)
            5'd0: return "t";   5'd1: return "r";   5'd2: return "a";
            5'd3: return "n";   5'd4: return "s";   5'd5: return "f";
            5'd6: return "e";   5'd7: return "r";   5'd8: return "-";
            5'd9: return "e";   5'd10: return "n";  5'd11: return "c";
            5'd12: return "o";  5'd13: return "d";  5'd14: return "i";
            5'd15: return "n";  5'd16: return "g";
            default: return ":";
        endcase
    endfunction

    function automatic logic [7:0] kw_chunked(input logic [2:0] i);
        case (i)
            3'd0: return "c";
            3'd1: return "h";
            3'd2: return "u";
            3'd3: return "n";
            3'd4: return "k";
            3'd5: return "e";
            default: return "d";
        endcase
    endfunction

endpackage

// ===== sv/hrbd_core.sv =====
// ----------------------------------------------------------------------------
// hrbd_core
// parser state and combinational step logic for one response byte
// ----------------------------------------------------------------------------
module hrbd_core #(
    parameter int MAX_LINE    = 4095,
    parameter int LENGTH_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_stream_end,
    output hrbd_pkg::t_result o_result
);
    import hrbd_pkg::*;

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int LB = LENGTH_BITS;
    localparam int PW = LB + 5;

    t_phase         r_phase, n_phase;
    logic [CW-1:0]  r_col, n_col;
    logic           r_prev_cr, n_prev_cr;
    logic [2:0]     r_stage, n_stage;
    logic [1:0]     r_cand, n_cand;
    logic [2:0]     r_kp, n_kp;
    logic [LB-1:0]  r_acc, n_acc;
    logic           r_neg, n_neg;
    logic [15:0]    r_status, n_status;
    logic [LB-1:0]  r_blen, n_blen;
    logic           r_lknown, n_lknown;
    logic           r_chunked, n_chunked;
    logic [LB-1:0]  r_remain, n_remain;
    logic [1:0]     r_tail, n_tail;

    // multiply-accumulate with saturation at the cap
    function automatic logic [LB-1:0] acc_add(input logic [LB-1:0] acc,
                                              input logic [3:0] d,
                                              input logic hex,
                                              input logic small_cap);
        logic [PW-1:0] prod;
        logic [PW-1:0] cap;
        prod = hex ? ({5'd0, acc} << 4) : (({5'd0, acc} << 3) + ({5'd0, acc} << 1));
        prod = prod + PW'(d);
        cap  = small_cap ? PW'(16'hFFFF) : {5'd0, {LB{1'b1}}};
        return (prod > cap) ? cap[LB-1:0] : prod[LB-1:0];
    endfunction

    // next state and result
    always_comb begin
        logic [7:0]    b;
        logic [4:0]    dg10, dg16;
        logic [CW-1:0] col1;
        logic          crlf, lend;
        n_phase = r_phase;   n_col = r_col;       n_prev_cr = r_prev_cr;
        n_stage = r_stage;   n_cand = r_cand;     n_kp = r_kp;
        n_acc = r_acc;       n_neg = r_neg;       n_status = r_status;
        n_blen = r_blen;     n_lknown = r_lknown; n_chunked = r_chunked;
        n_remain = r_remain; n_tail = r_tail;
        o_result = '0;
        b    = i_data_byte;
        dg10 = digit_of(b, 1'b0);
        dg16 = digit_of(b, 1'b1);
        col1 = r_col + CW'(1);
        crlf = r_prev_cr && (b == CH_LF);
        lend = crlf || (col1 >= CW'(MAX_LINE));

        if (i_stream_end) begin
            case (r_phase)
                PH_STATUS:  o_result.event_res = EV_CLOSED;
                PH_HEADERS: o_result.event_res = (r_status == 16'd200) ? EV_DONE : EV_NOT_200;
                PH_CSIZE, PH_CDATA, PH_CTAIL: o_result.event_res = EV_BAD_CHUNK;
                PH_DONE:    o_result.event_res = EV_NONE;
                default:    o_result.event_res = EV_DONE;
            endcase
            if (o_result.event_res == EV_DONE || o_result.event_res == EV_NOT_200)
                o_result.status_value = r_status;
            n_phase = PH_STATUS; n_col = '0; n_prev_cr = 1'b0; n_stage = '0;
            n_cand = 2'b11; n_kp = '0; n_acc = '0; n_neg = 1'b0; n_status = '0;
            n_blen = '0; n_lknown = 1'b0; n_chunked = 1'b0; n_remain = '0; n_tail = '0;
        end else begin
            case (r_phase)
                // status line
                PH_STATUS: begin
                    case (r_stage)
                        SS_LITERAL: begin
                            if (b == kw_http(r_kp)) begin
                                n_kp = r_kp + 3'd1;
                                if (r_kp == 3'd4) n_stage = SS_SPACE1;
                            end else n_stage = SS_BAD;
                        end
                        SS_SPACE1: begin
                            if (b == 8'd0) n_stage = SS_BAD;
                            else if (!is_space(b)) n_stage = SS_TOKEN;
                        end
                        SS_TOKEN: begin
                            if (b == 8'd0) n_stage = SS_BAD;
                            else if (is_space(b)) n_stage = SS_SPACE2;
                        end
                        SS_SPACE2: begin
                            if (is_space(b)) n_stage = r_stage;
                            else if (b == "+" || b == "-") begin
                                n_neg = (b == "-"); n_stage = SS_SIGN;
                            end else if (dg10[4]) begin
                                n_acc = acc_add(r_acc, dg10[3:0], 1'b0, 1'b1);
                                n_stage = SS_DIGITS;
                            end else n_stage = SS_BAD;
                        end
                        SS_SIGN: begin
                            if (dg10[4]) begin
                                n_acc = acc_add(r_acc, dg10[3:0], 1'b0, 1'b1);
                                n_stage = SS_DIGITS;
                            end else n_stage = SS_BAD;
                        end
                        SS_DIGITS: begin
                            if (dg10[4]) n_acc = acc_add(r_acc, dg10[3:0], 1'b0, 1'b1);
                            else n_stage = SS_OK;
                        end
                        default: n_stage = r_stage;
                    endcase
                    n_col = col1; n_prev_cr = (b == CH_CR);
                    if (lend) begin
                        if (n_stage == SS_DIGITS || n_stage == SS_OK) begin
                            n_status = n_neg ? 16'd0 : n_acc[15:0];
                            n_phase  = PH_HEADERS;
                        end else begin
                            o_result.event_res = EV_BAD_STAT;
                            n_phase = PH_DONE;
                        end
                        n_col = '0; n_prev_cr = 1'b0; n_stage = '0; n_cand = 2'b11;
                        n_kp = '0; n_acc = '0; n_neg = 1'b0;
                    end
                end
                // header lines
                PH_HEADERS: begin
                    if (r_col < CW'(15) && r_cand[0] && fold(b) != kw_clen(r_col[4:0]))
                        n_cand[0] = 1'b0;
                    if (r_col < CW'(18) && r_cand[1] && fold(b) != kw_tenc(r_col[4:0]))
                        n_cand[1] = 1'b0;
                    if (r_col >= CW'(15) && n_cand[0]) begin
                        if (r_stage == NS_LEAD && is_space(b)) n_stage = r_stage;
                        else if (r_stage == NS_LEAD && (b == "+" || b == "-")) begin
                            n_neg = (b == "-"); n_stage = NS_SIGNED;
                        end else if (r_stage <= NS_DIGITS && dg10[4]) begin
                            n_acc = acc_add(r_acc, dg10[3:0], 1'b0, 1'b0);
                            n_stage = NS_DIGITS;
                        end else n_stage = NS_STOPPED;
                    end
                    if (r_col >= CW'(18) && n_cand[1] && n_stage == 3'd0) begin
                        if (b == 8'd0) n_stage = 3'd1;
                        else if (r_kp < 3'd7) begin
                            if (b == kw_chunked(r_kp)) n_kp = r_kp + 3'd1;
                            else n_kp = (b == "c") ? 3'd1 : 3'd0;
                        end
                    end
                    n_col = col1; n_prev_cr = (b == CH_CR);
                    if (crlf && col1 == CW'(2)) begin
                        if (r_status != 16'd200) begin
                            o_result.event_res = EV_NOT_200;
                            o_result.status_value = r_status;
                            n_phase = PH_DONE;
                        end else if (r_chunked) n_phase = PH_CSIZE;
                        else if (r_lknown) begin
                            if (r_blen == '0) begin
                                o_result.event_res = EV_DONE;
                                o_result.status_value = r_status;
                                n_phase = PH_DONE;
                            end else begin
                                n_remain = r_blen; n_phase = PH_FIXED;
                            end
                        end else n_phase = PH_UNTIL_CLOSE;
                    end else if (lend) begin
                        if (n_cand[0] && col1 >= CW'(15)) begin
                            n_lknown = !(n_neg && n_acc != '0);
                            n_blen   = n_lknown ? n_acc : '0;
                        end
                        if (n_cand[1] && n_kp == 3'd7) n_chunked = 1'b1;
                    end
                    if (lend) begin
                        n_col = '0; n_prev_cr = 1'b0; n_stage = '0; n_cand = 2'b11;
                        n_kp = '0; n_acc = '0; n_neg = 1'b0;
                    end
                end
                // chunk size line
                PH_CSIZE: begin
                    if (r_stage == NS_LEAD && is_space(b)) n_stage = r_stage;
                    else if (r_stage == NS_LEAD && (b == "+" || b == "-")) begin
                        n_neg = (b == "-"); n_stage = NS_SIGNED;
                    end else if (r_stage <= NS_DIGITS && dg16[4]) begin
                        n_acc = acc_add(r_acc, dg16[3:0], 1'b1, 1'b0);
                        n_stage = NS_DIGITS;
                    end else n_stage = NS_STOPPED;
                    n_col = col1; n_prev_cr = (b == CH_CR);
                    if (lend) begin
                        if (n_neg || n_acc == '0) n_phase = PH_CTRAILER;
                        else begin
                            n_remain = n_acc; n_phase = PH_CDATA;
                        end
                        n_col = '0; n_prev_cr = 1'b0; n_stage = '0; n_cand = 2'b11;
                        n_kp = '0; n_acc = '0; n_neg = 1'b0;
                    end
                end
                PH_CDATA: begin
                    o_result.event_res = EV_BODY; o_result.body_byte = b;
                    n_remain = r_remain - LB'(1);
                    if (n_remain == '0) begin
                        n_tail = 2'd2; n_phase = PH_CTAIL;
                    end
                end
                PH_CTAIL: begin
                    if (r_tail != 2'd0) n_tail = r_tail - 2'd1;
                    if (n_tail == 2'd0) begin
                        n_phase = PH_CSIZE;
                        n_col = '0; n_prev_cr = 1'b0; n_stage = '0; n_cand = 2'b11;
                        n_kp = '0; n_acc = '0; n_neg = 1'b0;
                    end
                end
                PH_CTRAILER: begin
                    n_col = col1; n_prev_cr = (b == CH_CR);
                    if (lend) begin
                        o_result.event_res = EV_DONE;
                        o_result.status_value = r_status;
                        n_phase = PH_DONE;
                        n_col = '0; n_prev_cr = 1'b0; n_stage = '0; n_cand = 2'b11;
                        n_kp = '0; n_acc = '0; n_neg = 1'b0;
                    end
                end
                PH_FIXED: begin
                    o_result.event_res = EV_BODY; o_result.body_byte = b;
                    n_remain = r_remain - LB'(1);
                    if (n_remain == '0) n_phase = PH_FIXED_END;
                end
                PH_FIXED_END: begin
                    o_result.event_res = EV_DONE;
                    o_result.status_value = r_status;
                    n_phase = PH_DONE;
                end
                PH_UNTIL_CLOSE: begin
                    o_result.event_res = EV_BODY; o_result.body_byte = b;
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_STATUS; r_col <= '0; r_prev_cr <= 1'b0; r_stage <= '0;
            r_cand <= 2'b11; r_kp <= '0; r_acc <= '0; r_neg <= 1'b0; r_status <= '0;
            r_blen <= '0; r_lknown <= 1'b0; r_chunked <= 1'b0; r_remain <= '0;
            r_tail <= '0;
        end else if (i_step) begin
            r_phase <= n_phase; r_col <= n_col; r_prev_cr <= n_prev_cr;
            r_stage <= n_stage; r_cand <= n_cand; r_kp <= n_kp; r_acc <= n_acc;
            r_neg <= n_neg; r_status <= n_status; r_blen <= n_blen;
            r_lknown <= n_lknown; r_chunked <= n_chunked; r_remain <= n_remain;
            r_tail <= n_tail;
        end
    end

endmodule

// ===== sv/http_response_body_deframer.sv =====
// an accepted byte goes from the input register through the parser step into the result register
// throughput: one byte per cycle while the output register is free or being taken, set by the combinational parser step
// the input register stalls only while the output register is held
// reset: synchronous active-low, parser returns to the status line phase
// ----------------------------------------------------------------------------
// http_response_body_deframer
// input register, parser core and result register of the body deframer
// ----------------------------------------------------------------------------
module http_response_body_deframer #(
    parameter int MAX_LINE    = 4095,
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_end,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_body_byte,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_status_value
);
    import hrbd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_res;
    logic       adv;
    logic       step;

    // advance when the output register is free or being taken
    assign adv        = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    hrbd_core #(
        .MAX_LINE    (MAX_LINE),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (r_in_byte),
        .i_stream_end (r_in_end),
        .o_result     (core_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_end  <= i_stream_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_body_byte    = r_out.body_byte;
    assign o_event_res    = r_out.event_res;
    assign o_status_value = r_out.status_value;

endmodule

// ===== sim/http_response_body_deframer_test.sv =====
// ----------------------------------------------------------------------------
// http_response_body_deframer_test
// self-checking bench for the response body deframer: byte streams of whole
// responses (fixed length, chunked, until close, broken) go in, a software
// twin of the parser predicts each result and every output transaction is
// checked field by field in order
// ----------------------------------------------------------------------------
module http_response_body_deframer_test;
    import hrbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE = 4095;
    localparam longint unsigned LEN_CAP = 64'hFFFF_FFFF;
    localparam longint unsigned STATUS_CAP = 64'd65535;
    localparam string KW_HTTP = "HTTP/";
    localparam string KW_CLEN = "content-length:";
    localparam string KW_TENC = "transfer-encoding:";
    localparam string KW_CHUNKED = "chunked";

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_stream_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_body_byte;
    logic [2:0]  o_event_res;
    logic [15:0] o_status_value;

    http_response_body_deframer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_stream_end   (i_stream_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_body_byte    (o_body_byte),
        .o_event_res    (o_event_res),
        .o_status_value (o_status_value)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // parser twin state
    t_phase          ph;
    int              col;
    bit              prev_cr;
    int              stg;
    bit [1:0]        cand;
    int              kw;
    longint unsigned acc;
    bit              neg;
    logic [15:0]     status_num;
    longint unsigned blen;
    bit              len_known;
    bit              chunked;
    longint unsigned remaining;
    int              tail;

    t_result expected_q[$];
    int      mismatches;
    int      bytes_sent;
    int      responses_sent;
    int      body_seen;
    int      done_seen;
    int      error_seen;
    bit      idle_on;
    int      hold_left;

    function automatic bit white(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    // digit value in base 10 or 16, -1 when not a digit
    function automatic int digit_val(input logic [7:0] b, input bit hex);
        logic [7:0] f;
        f = lower(b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (hex && f >= "a" && f <= "f") return int'(f - "a") + 10;
        return -1;
    endfunction

    function automatic void acc_add(input int d, input longint unsigned base,
                                    input longint unsigned cap);
        if (acc > (cap - longint'(d)) / base) acc = cap;
        else acc = acc * base + longint'(d);
    endfunction

    function automatic void line_clear();
        col = 0;
        prev_cr = 0;
        stg = 0;
        cand = 2'b11;
        kw = 0;
        acc = 0;
        neg = 0;
    endfunction

    function automatic void parser_clear();
        ph = PH_STATUS;
        line_clear();
        status_num = 0;
        blen = 0;
        len_known = 0;
        chunked = 0;
        remaining = 0;
        tail = 0;
    endfunction

    // 0 line goes on, 1 line limit, 2 crlf
    function automatic int line_count(input logic [7:0] b);
        bit crlf;
        crlf = prev_cr && b == CH_LF;
        col++;
        prev_cr = (b == CH_CR);
        if (crlf) return 2;
        if (col >= MAX_LINE) return 1;
        return 0;
    endfunction

    // signed number field: lead space, sign, digits, stopped
    function automatic void number_step(input logic [7:0] b, input bit hex);
        int d;
        d = digit_val(b, hex);
        if (stg == int'(NS_LEAD)) begin
            if (white(b)) return;
            if (b == "+" || b == "-") begin
                neg = (b == "-");
                stg = NS_SIGNED;
                return;
            end
        end
        if (stg <= int'(NS_DIGITS) && d >= 0) begin
            acc_add(d, hex ? 16 : 10, LEN_CAP);
            stg = NS_DIGITS;
            return;
        end
        stg = NS_STOPPED;
    endfunction

    function automatic void status_step(input logic [7:0] b);
        int d;
        d = digit_val(b, 0);
        case (stg)
            int'(SS_LITERAL): begin
                if (kw < 5 && b == KW_HTTP[kw]) begin
                    kw++;
                    if (kw == 5) stg = SS_SPACE1;
                end else stg = SS_BAD;
            end
            int'(SS_SPACE1): begin
                if (b == 8'h00) stg = SS_BAD;
                else if (!white(b)) stg = SS_TOKEN;
            end
            int'(SS_TOKEN): begin
                if (b == 8'h00) stg = SS_BAD;
                else if (white(b)) stg = SS_SPACE2;
            end
            int'(SS_SPACE2): begin
                if (!white(b)) begin
                    if (b == "+" || b == "-") begin
                        neg = (b == "-");
                        stg = SS_SIGN;
                    end else if (d >= 0) begin
                        acc_add(d, 10, STATUS_CAP);
                        stg = SS_DIGITS;
                    end else stg = SS_BAD;
                end
            end
            int'(SS_SIGN): begin
                if (d >= 0) begin
                    acc_add(d, 10, STATUS_CAP);
                    stg = SS_DIGITS;
                end else stg = SS_BAD;
            end
            int'(SS_DIGITS): begin
                if (d >= 0) acc_add(d, 10, STATUS_CAP);
                else stg = SS_OK;
            end
            default: ;
        endcase
    endfunction

    function automatic void header_step(input logic [7:0] b, input int pos);
        if (pos < 15 && cand[0] && lower(b) != KW_CLEN[pos]) cand[0] = 0;
        if (pos < 18 && cand[1] && lower(b) != KW_TENC[pos]) cand[1] = 0;
        if (pos >= 15 && cand[0]) number_step(b, 0);
        if (pos >= 18 && cand[1] && stg == 0) begin
            if (b == 8'h00) stg = 1;
            else if (kw < 7) begin
                if (b == KW_CHUNKED[kw]) kw++;
                else kw = (b == "c") ? 1 : 0;
            end
        end
    endfunction

    // one accepted transaction in, one expected result out
    function automatic t_result parse_byte(input logic [7:0] b, input bit fin);
        t_result r;
        int      lr;
        r = '0;
        if (fin) begin
            case (ph)
                PH_STATUS: r.event_res = EV_CLOSED;
                PH_HEADERS: r.event_res = (status_num == 200) ? EV_DONE : EV_NOT_200;
                PH_CSIZE, PH_CDATA, PH_CTAIL: r.event_res = EV_BAD_CHUNK;
                PH_DONE: r.event_res = EV_NONE;
                default: r.event_res = EV_DONE;
            endcase
            if (r.event_res == EV_DONE || r.event_res == EV_NOT_200)
                r.status_value = status_num;
            parser_clear();
            return r;
        end
        case (ph)
            PH_STATUS: begin
                status_step(b);
                if (line_count(b) != 0) begin
                    if (stg == int'(SS_DIGITS) || stg == int'(SS_OK)) begin
                        status_num = neg ? 16'd0 : acc[15:0];
                        ph = PH_HEADERS;
                    end else begin
                        r.event_res = EV_BAD_STAT;
                        ph = PH_DONE;
                    end
                    line_clear();
                end
            end
            PH_HEADERS: begin
                header_step(b, col);
                lr = line_count(b);
                if (lr == 2 && col == 2) begin
                    if (status_num != 200) begin
                        r.event_res = EV_NOT_200;
                        r.status_value = status_num;
                        ph = PH_DONE;
                    end else if (chunked) ph = PH_CSIZE;
                    else if (len_known) begin
                        if (blen == 0) begin
                            r.event_res = EV_DONE;
                            r.status_value = status_num;
                            ph = PH_DONE;
                        end else begin
                            remaining = blen;
                            ph = PH_FIXED;
                        end
                    end else ph = PH_UNTIL_CLOSE;
                    line_clear();
                end else if (lr != 0) begin
                    if (cand[0] && col >= 15) begin
                        len_known = !(neg && acc != 0);
                        blen = len_known ? acc : 0;
                    end
                    if (cand[1] && kw == 7) chunked = 1;
                    line_clear();
                end
            end
            PH_CSIZE: begin
                number_step(b, 1);
                if (line_count(b) != 0) begin
                    if (neg || acc == 0) ph = PH_CTRAILER;
                    else begin
                        remaining = acc;
                        ph = PH_CDATA;
                    end
                    line_clear();
                end
            end
            PH_CDATA: begin
                r.event_res = EV_BODY;
                r.body_byte = b;
                remaining--;
                if (remaining == 0) begin
                    tail = 2;
                    ph = PH_CTAIL;
                end
            end
            PH_CTAIL: begin
                if (tail > 0) tail--;
                if (tail == 0) begin
                    ph = PH_CSIZE;
                    line_clear();
                end
            end
            PH_CTRAILER: begin
                if (line_count(b) != 0) begin
                    r.event_res = EV_DONE;
                    r.status_value = status_num;
                    ph = PH_DONE;
                    line_clear();
                end
            end
            PH_FIXED: begin
                r.event_res = EV_BODY;
                r.body_byte = b;
                remaining--;
                if (remaining == 0) ph = PH_FIXED_END;
            end
            PH_FIXED_END: begin
                r.event_res = EV_DONE;
                r.status_value = status_num;
                ph = PH_DONE;
            end
            PH_UNTIL_CLOSE: begin
                r.event_res = EV_BODY;
                r.body_byte = b;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // predict on every accepted input transaction
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_q.push_back(parse_byte(i_data_byte, i_stream_end));
    end

    // compare every accepted output transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_q.pop_front();
                if (o_event_res !== e.event_res)
                    report_mismatch($sformatf("event %0d, expected %0d",
                                              o_event_res, e.event_res));
                if (o_body_byte !== e.body_byte)
                    report_mismatch($sformatf("body byte %02h, expected %02h",
                                              o_body_byte, e.body_byte));
                if (o_status_value !== e.status_value)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status_value, e.status_value));
                if (e.event_res == EV_BODY) body_seen++;
                else if (e.event_res == EV_DONE) done_seen++;
                else if (e.event_res != EV_NONE) error_seen++;
            end
        end
    end

    // receiver: random stalls, or a long forced hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < 34);
        end
    end

    // one input transaction, with random idle cycles before it
    task automatic send_item(input logic [7:0] b, input bit fin);
        while (idle_on && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= b;
        i_stream_end <= fin;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (fin) responses_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[k]) send_item(s[k], 0);
    endtask

    task automatic send_close();
        send_item(8'($urandom), 1);
    endtask

    function automatic string hex_text(input int v);
        string s;
        s = $sformatf("%0h", v);
        if ($urandom_range(1)) s = s.toupper();
        return s;
    endfunction

    function automatic string mixed_case(input string s);
        string o;
        o = s;
        foreach (o[k]) if ($urandom_range(1)) o[k] = (o[k] >= "a" && o[k] <= "z") ?
                                                     o[k] - 8'd32 : o[k];
        return o;
    endfunction

    task automatic send_random_bytes(input int n);
        repeat (n) send_item(8'($urandom), 0);
    endtask

    // well-formed response with random content; broken now and then
    task automatic send_response();
        int    code;
        int    mode;
        int    len;
        int    n;
        string s;
        code = ($urandom_range(9) < 8) ? 200 : $urandom_range(999);
        s = ($urandom_range(9) == 0) ? "HTTP/2 " : "HTTP/1.1 ";
        if ($urandom_range(19) == 0) s = "HTTX/1.1 ";
        send_text({s, $sformatf("%0d", code),
                   ($urandom_range(1) ? " OK" : ""), "\r\n"});
        mode = $urandom_range(2);
        len = $urandom_range(12);
        if ($urandom_range(1)) send_text("Host: x\r\n");
        if (mode == 0)
            send_text({mixed_case("content-length:"),
                       ($urandom_range(1) ? " " : ""), $sformatf("%0d", len), "\r\n"});
        if (mode == 1)
            send_text({mixed_case("transfer-encoding:"),
                       ($urandom_range(1) ? " gzip, chunked" : " chunked"), "\r\n"});
        send_text("\r\n");
        if (mode == 1) begin
            n = $urandom_range(3);
            repeat (n) begin
                len = $urandom_range(1, 9);
                send_text({hex_text(len), ($urandom_range(3) == 0 ? ";x=1" : ""), "\r\n"});
                send_random_bytes(len);
                send_text("\r\n");
            end
            if ($urandom_range(9) != 0) send_text("0\r\n\r\n");
        end else begin
            send_random_bytes(len + $urandom_range(3));
        end
        send_close();
    endtask

    task automatic test_directed();
        send_close();
        send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\nabcZ");
        send_close();
        send_text("HTTP/1.1 200 OK\r\nTransfer-Encoding: chunked\r\n\r\n");
        send_text("a\r\n0123456789\r\n-1\r\ntrailer\r\n");
        send_close();
        send_text("HTTP/1.0 404 Not Found\r\n\r\nxx");
        send_close();
        send_text("HTTP 200\r\n");
        send_close();
        send_text("HTTP/1.1 +99999999\r\nCONTENT-LENGTH: -5\r\n\r\n");
        send_item(8'hFF, 0);
        send_item(8'h00, 0);
        send_close();
        send_text("HTTP/1.1 -200\r\n\r\n");
        send_close();
        send_text("HTTP/1.1 200\r\ncontent-length:\r\n\r\n");
        send_close();
        send_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\nab");
        send_close();
        // zero byte inside the status line
        send_text("HTTP/");
        send_item(8'h00, 0);
        send_text(" 200\r\n");
        send_close();
        // zero byte inside the transfer encoding value
        send_text("HTTP/1.1 200\r\nTransfer-Encoding: ch");
        send_item(8'h00, 0);
        send_text("unked\r\n\r\nq");
        send_close();
        send_text("HTTP/1.1 200\r\nTransfer-Encoding: chunked\r\n\r\nFFFFFFFFFF\r\nab");
        send_close();
        send_text("HTTP/1.1 200\r\nhdr");
        send_close();
    endtask

    task automatic test_random();
        int noise;
        while (bytes_sent < 1800) begin
            noise = $urandom_range(9);
            if (noise == 0) begin
                send_random_bytes($urandom_range(1, 30));
                send_close();
            end else begin
                send_response();
            end
        end
    endtask

    // stretch with no idling on either side
    task automatic test_no_idle();
        idle_on = 0;
        repeat (6) send_response();
        idle_on = 1;
    endtask

    // receiver holds off while the sender keeps offering body bytes
    task automatic test_backpressure();
        idle_on = 0;
        send_text("HTTP/1.1 200 OK\r\n\r\n");
        hold_left = 300;
        send_random_bytes(60);
        send_close();
        idle_on = 1;
    endtask

    initial begin
        int waited;
        mismatches = 0;
        bytes_sent = 0;
        responses_sent = 0;
        body_seen = 0;
        done_seen = 0;
        error_seen = 0;
        idle_on = 1;
        hold_left = 0;
        parser_clear();
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_data_byte <= 8'h00;
        i_stream_end <= 1'b0;
        i_out_stall <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_no_idle();
        test_random();

        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        $display("covered %0d responses, %0d bytes in", responses_sent, bytes_sent);
        $display("checked %0d body bytes, %0d done, %0d error events",
                 body_seen, done_seen, error_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule
